// ----- hw/rtl/abd_pkg.sv -----
// Anchor box decode package: request/response payload types, CSR and channel
// codes, sigmoid table. No dependencies.
`default_nettype none

package abd_pkg;

   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AFF_XX    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AFF_XY    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AFF_XOFF  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AFF_YX    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_AFF_YY    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_AFF_YOFF  = 3'd6;

   localparam logic [6:0] CH_X   = 7'd0;
   localparam logic [6:0] CH_Y   = 7'd1;
   localparam logic [6:0] CH_W   = 7'd2;
   localparam logic [6:0] CH_H   = 7'd3;
   localparam logic [6:0] CH_OBJ = 7'd4;
   localparam logic [6:0] CH_CLS = 7'd5;

   typedef struct packed {
      logic signed [15:0] logit;
      logic               last_channel;
      logic [7:0]         cell_x;
      logic [7:0]         cell_y;
      logic [6:0]         grid_stride;
      logic [9:0]         anchor_width;
      logic [9:0]         anchor_height;
   } req_type;

   typedef struct packed {
      logic signed [31:0] box_left;
      logic signed [31:0] box_top;
      logic signed [31:0] box_right;
      logic signed [31:0] box_bottom;
      logic [15:0]        box_confidence;
      logic [6:0]         class_label;
   } rsp_type;

   // table lookup result handed to the sequencer
   typedef struct packed {
      logic        neg;
      logic [15:0] base;
      logic [11:0] diff;
      logic [7:0]  frac;
   } sig_type;

   // round(65536 * sigmoid(k/4)), k = 0..32
   function automatic logic [15:0] sig_tab(input logic [5:0] k);
      logic [15:0] v;
      unique case (k)
         6'd0:  v = 16'd32768;
         6'd1:  v = 16'd36843;
         6'd2:  v = 16'd40793;
         6'd3:  v = 16'd44511;
         6'd4:  v = 16'd47911;
         6'd5:  v = 16'd50941;
         6'd6:  v = 16'd53581;
         6'd7:  v = 16'd55834;
         6'd8:  v = 16'd57724;
         6'd9:  v = 16'd59287;
         6'd10: v = 16'd60565;
         6'd11: v = 16'd61598;
         6'd12: v = 16'd62428;
         6'd13: v = 16'd63090;
         6'd14: v = 16'd63615;
         6'd15: v = 16'd64030;
         6'd16: v = 16'd64357;
         6'd17: v = 16'd64614;
         6'd18: v = 16'd64816;
         6'd19: v = 16'd64974;
         6'd20: v = 16'd65097;
         6'd21: v = 16'd65194;
         6'd22: v = 16'd65269;
         6'd23: v = 16'd65328;
         6'd24: v = 16'd65374;
         6'd25: v = 16'd65410;
         6'd26: v = 16'd65438;
         6'd27: v = 16'd65459;
         6'd28: v = 16'd65476;
         6'd29: v = 16'd65489;
         6'd30: v = 16'd65500;
         6'd31: v = 16'd65508;
         default: v = 16'd65514;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/anchor_box_decode_unit.sv -----
// Anchor box decoder top: channel sequencer, box decode sequencer, CSRs.
// Depends on abd_pkg, abd_mul, abd_sig_lut.
//
//   port group   dir  handshake            payload
//   req_*        in   req_valid/req_stall  abd_pkg::req_type
//   rsp_*        out  rsp_valid/rsp_stall  abd_pkg::rsp_type
//   csr_*        in   csr_write            csr_index, csr_wdata
//
// A channel request passes accept, sigmoid multiply and state update.
// The last channel adds 18 box steps, all on the one shared multiplier, and
// emit, which drops a box below threshold or waits out a stalled response.
// Reset is synchronous; it clears item state and loads CSR defaults.
// A pending response is held in its own register, so requests are taken
// while it is stalled.
`default_nettype none

module anchor_box_decode_unit #(
   parameter int CHANNELS = 85
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire abd_pkg::req_type                 req_payload,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output abd_pkg::rsp_type                      rsp_payload,
   input  wire logic                             csr_write,
   input  wire logic [abd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [31:0]                      csr_wdata
);

   localparam logic [7:0] CH_LIMIT = 8'(CHANNELS);
   localparam logic [4:0] LAST_STEP = 5'd17;

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_SIG_MUL = 5'b00010,
      S_SIG_UPD = 5'b00100,
      S_BOX     = 5'b01000,
      S_EMIT    = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   abd_pkg::req_type req_ff, req_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [15:0] x_ff, x_in, y_ff, y_in, w_ff, w_in, h_ff, h_in;
   logic [15:0] obj_ff, obj_in, best_ff, best_in;
   logic [6:0]  label_ff, label_in;
   logic [15:0] thr_ff, thr_in;
   logic [31:0] axx_ff, axx_in, axy_ff, axy_in, axo_ff, axo_in;
   logic [31:0] ayx_ff, ayx_in, ayy_ff, ayy_in, ayo_ff, ayo_in;
   logic [4:0]  step_ff, step_in;
   logic [15:0] conf_ff, conf_in;
   logic [31:0] ww_ff, ww_in, hh2_ff, hh2_in;
   logic [28:0] hw_ff, hw_in, hh_ff, hh_in;
   logic [33:0] mx_ff, mx_in, my_ff, my_in;
   logic [25:0] el_ff, el_in, er_ff, er_in, et_ff, et_in, eb_ff, eb_in;
   logic [65:0] acc_ff, acc_in;
   logic [31:0] bl_ff, bl_in, bt_ff, bt_in, br_ff, br_in, bb_ff, bb_in;
   abd_pkg::rsp_type out_ff, out_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod;
   abd_pkg::sig_type   lut;

   logic [20:0] interp;
   logic [16:0] sig_v;
   logic [15:0] prob;
   logic [42:0] half_sum;
   logic [9:0]  cell_m;
   logic [34:0] lo_sum, hi_sum;
   logic [65:0] off_x, off_y, fin_sum;
   logic [31:0] fin_sat;
   logic        emit;
   logic        clear;

   abd_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   abd_sig_lut u_lut (
      .logit (req_ff.logit),
      .lut   (lut)
   );

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = out_ff;

   always_comb begin
      interp = prod[20:0] + 21'd128;
      sig_v  = {1'b0, lut.base} + {4'b0, interp[20:8]};
      prob   = lut.neg ? 16'(17'h10000 - sig_v) : sig_v[15:0];

      half_sum = {1'b0, prod[41:0]} + 43'd8192;
      cell_m   = 10'({2'b0, (step_ff == 5'd5) ? req_ff.cell_x : req_ff.cell_y, 1'b0} - 11'd1);

      lo_sum = (step_ff == 5'd7) ? ({mx_ff[33], mx_ff} - {6'b0, hw_ff} + 35'd256)
                                 : ({my_ff[33], my_ff} - {6'b0, hh_ff} + 35'd256);
      hi_sum = (step_ff == 5'd7) ? ({mx_ff[33], mx_ff} + {6'b0, hw_ff} + 35'd256)
                                 : ({my_ff[33], my_ff} + {6'b0, hh_ff} + 35'd256);

      off_x   = {{26{axo_ff[31]}}, axo_ff, 8'b0} + 66'd32768;
      off_y   = {{26{ayo_ff[31]}}, ayo_ff, 8'b0} + 66'd32768;
      fin_sum = acc_ff + prod;
      if (fin_sum[65:47] == {19{fin_sum[65]}}) begin
         fin_sat = fin_sum[47:16];
      end else begin
         fin_sat = fin_sum[65] ? 32'h8000_0000 : 32'h7fff_ffff;
      end

      emit = (obj_ff >= thr_ff) && (conf_ff >= thr_ff);
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_SIG_MUL) begin
         mul_a = {21'b0, lut.diff};
         mul_b = {25'b0, lut.frac};
      end else if (state_ff == S_BOX) begin
         unique case (step_ff)
            5'd0: begin
               mul_a = {17'b0, obj_ff};
               mul_b = {17'b0, best_ff};
            end
            5'd1: begin
               mul_a = {17'b0, w_ff};
               mul_b = {17'b0, w_ff};
            end
            5'd2: begin
               mul_a = {17'b0, h_ff};
               mul_b = {17'b0, h_ff};
            end
            5'd3: begin
               mul_a = {1'b0, ww_ff};
               mul_b = {23'b0, req_ff.anchor_width};
            end
            5'd4: begin
               mul_a = {1'b0, hh2_ff};
               mul_b = {23'b0, req_ff.anchor_height};
            end
            5'd5: begin
               mul_a = 33'({15'b0, x_ff, 2'b00}) + {{7{cell_m[9]}}, cell_m, 16'b0};
               mul_b = {26'b0, req_ff.grid_stride};
            end
            5'd6: begin
               mul_a = 33'({15'b0, y_ff, 2'b00}) + {{7{cell_m[9]}}, cell_m, 16'b0};
               mul_b = {26'b0, req_ff.grid_stride};
            end
            5'd9: begin
               mul_a = {axx_ff[31], axx_ff};
               mul_b = {{7{el_ff[25]}}, el_ff};
            end
            5'd10: begin
               mul_a = {axy_ff[31], axy_ff};
               mul_b = {{7{et_ff[25]}}, et_ff};
            end
            5'd11: begin
               mul_a = {ayx_ff[31], ayx_ff};
               mul_b = {{7{el_ff[25]}}, el_ff};
            end
            5'd12: begin
               mul_a = {ayy_ff[31], ayy_ff};
               mul_b = {{7{et_ff[25]}}, et_ff};
            end
            5'd13: begin
               mul_a = {axx_ff[31], axx_ff};
               mul_b = {{7{er_ff[25]}}, er_ff};
            end
            5'd14: begin
               mul_a = {axy_ff[31], axy_ff};
               mul_b = {{7{eb_ff[25]}}, eb_ff};
            end
            5'd15: begin
               mul_a = {ayx_ff[31], ayx_ff};
               mul_b = {{7{er_ff[25]}}, er_ff};
            end
            5'd16: begin
               mul_a = {ayy_ff[31], ayy_ff};
               mul_b = {{7{eb_ff[25]}}, eb_ff};
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cnt_in       = cnt_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      obj_in       = obj_ff;
      best_in      = best_ff;
      label_in     = label_ff;
      thr_in       = thr_ff;
      axx_in       = axx_ff;
      axy_in       = axy_ff;
      axo_in       = axo_ff;
      ayx_in       = ayx_ff;
      ayy_in       = ayy_ff;
      ayo_in       = ayo_ff;
      step_in      = step_ff;
      conf_in      = conf_ff;
      ww_in        = ww_ff;
      hh2_in       = hh2_ff;
      hw_in        = hw_ff;
      hh_in        = hh_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      el_in        = el_ff;
      er_in        = er_ff;
      et_in        = et_ff;
      eb_in        = eb_ff;
      acc_in       = acc_ff;
      bl_in        = bl_ff;
      bt_in        = bt_ff;
      br_in        = br_ff;
      bb_in        = bb_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      clear        = 1'b0;

      if (csr_write) begin
         unique case (csr_index)
            abd_pkg::CSR_THRESHOLD: thr_in = csr_wdata[15:0];
            abd_pkg::CSR_AFF_XX:    axx_in = csr_wdata;
            abd_pkg::CSR_AFF_XY:    axy_in = csr_wdata;
            abd_pkg::CSR_AFF_XOFF:  axo_in = csr_wdata;
            abd_pkg::CSR_AFF_YX:    ayx_in = csr_wdata;
            abd_pkg::CSR_AFF_YY:    ayy_in = csr_wdata;
            abd_pkg::CSR_AFF_YOFF:  ayo_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = S_SIG_MUL;
            end
         end
         S_SIG_MUL: begin
            state_in = S_SIG_UPD;
         end
         S_SIG_UPD: begin
            if ({1'b0, cnt_ff} < CH_LIMIT) begin
               unique case (cnt_ff)
                  abd_pkg::CH_X:   x_in   = prob;
                  abd_pkg::CH_Y:   y_in   = prob;
                  abd_pkg::CH_W:   w_in   = prob;
                  abd_pkg::CH_H:   h_in   = prob;
                  abd_pkg::CH_OBJ: obj_in = prob;
                  default: begin
                     if (prob > best_ff) begin
                        best_in  = prob;
                        label_in = 7'(cnt_ff - abd_pkg::CH_CLS);
                     end
                  end
               endcase
            end
            if (req_ff.last_channel) begin
               step_in  = 5'd0;
               state_in = S_BOX;
            end else begin
               if (cnt_ff != 7'd127) begin
                  cnt_in = cnt_ff + 7'd1;
               end
               state_in = S_IDLE;
            end
         end
         S_BOX: begin
            step_in = step_ff + 5'd1;
            unique case (step_ff)
               5'd1:  conf_in = prod[31:16] + {15'b0, prod[15]};
               5'd2:  ww_in   = prod[31:0];
               5'd3:  hh2_in  = prod[31:0];
               5'd4:  hw_in   = half_sum[42:14];
               5'd5:  hh_in   = half_sum[42:14];
               5'd6:  mx_in   = prod[33:0];
               5'd7: begin
                  my_in = prod[33:0];
                  el_in = lo_sum[34:9];
                  er_in = hi_sum[34:9];
               end
               5'd8: begin
                  et_in = lo_sum[34:9];
                  eb_in = hi_sum[34:9];
               end
               5'd10: acc_in = prod + off_x;
               5'd11: bl_in  = fin_sat;
               5'd12: acc_in = prod + off_y;
               5'd13: bt_in  = fin_sat;
               5'd14: acc_in = prod + off_x;
               5'd15: br_in  = fin_sat;
               5'd16: acc_in = prod + off_y;
               5'd17: bb_in  = fin_sat;
               default: ;
            endcase
            if (step_ff == LAST_STEP) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!emit) begin
               clear    = 1'b1;
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               out_in.box_left       = bl_ff;
               out_in.box_top        = bt_ff;
               out_in.box_right      = br_ff;
               out_in.box_bottom     = bb_ff;
               out_in.box_confidence = conf_ff;
               out_in.class_label    = label_ff;
               rsp_valid_in          = 1'b1;
               clear                 = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (clear) begin
         cnt_in   = '0;
         x_in     = '0;
         y_in     = '0;
         w_in     = '0;
         h_in     = '0;
         obj_in   = '0;
         best_in  = '0;
         label_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         w_ff         <= '0;
         h_ff         <= '0;
         obj_ff       <= '0;
         best_ff      <= '0;
         label_ff     <= '0;
         step_ff      <= '0;
         thr_ff       <= 16'd16384;
         axx_ff       <= 32'd65536;
         axy_ff       <= '0;
         axo_ff       <= '0;
         ayx_ff       <= '0;
         ayy_ff       <= 32'd65536;
         ayo_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         w_ff         <= w_in;
         h_ff         <= h_in;
         obj_ff       <= obj_in;
         best_ff      <= best_in;
         label_ff     <= label_in;
         step_ff      <= step_in;
         thr_ff       <= thr_in;
         axx_ff       <= axx_in;
         axy_ff       <= axy_in;
         axo_ff       <= axo_in;
         ayx_ff       <= ayx_in;
         ayy_ff       <= ayy_in;
         ayo_ff       <= ayo_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      conf_ff <= conf_in;
      ww_ff   <= ww_in;
      hh2_ff  <= hh2_in;
      hw_ff   <= hw_in;
      hh_ff   <= hh_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      el_ff   <= el_in;
      er_ff   <= er_in;
      et_ff   <= et_in;
      eb_ff   <= eb_in;
      acc_ff  <= acc_in;
      bl_ff   <= bl_in;
      bt_ff   <= bt_in;
      br_ff   <= br_in;
      bb_ff   <= bb_in;
      out_ff  <= out_in;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/abd_mul.sv -----
// Shared signed 33x33 multiplier with registered product.
// Depends on nothing.
`default_nettype none

module abd_mul (
   input  wire logic               clock,
   input  wire logic signed [32:0] mul_a,
   input  wire logic signed [32:0] mul_b,
   output logic signed [65:0]      prod_ff
);

   logic signed [65:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/abd_sig_lut.sv -----
// Sigmoid table front end: magnitude clamp, segment lookup and slope.
// Depends on abd_pkg.
`default_nettype none

module abd_sig_lut (
   input  wire logic signed [15:0] logit,
   output abd_pkg::sig_type        lut
);

   logic [15:0] mag;
   logic        sat;
   logic [5:0]  idx;
   logic [15:0] lo;
   logic [15:0] hi;

   always_comb begin
      mag = logit[15] ? 16'(-logit) : logit;
      sat = |mag[15:13];
      idx = {1'b0, mag[12:8]};
      lo  = abd_pkg::sig_tab(idx);
      hi  = abd_pkg::sig_tab(6'(idx + 6'd1));
      lut.neg  = logit[15];
      lut.base = sat ? abd_pkg::sig_tab(6'd32) : lo;
      lut.diff = sat ? 12'd0 : 12'(hi - lo);
      lut.frac = sat ? 8'd0 : mag[7:0];
   end

endmodule

`default_nettype wire

// ----- hw/rtl/abd_checker.sv -----
// Port-level checker for anchor_box_decode_unit and its bind.
// Depends on abd_pkg.
`default_nettype none

module abd_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire abd_pkg::req_type              req_payload,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire abd_pkg::rsp_type              rsp_payload,
   input wire logic                          csr_write,
   input wire logic [abd_pkg::CSR_IDX_W-1:0] csr_index,
   input wire logic [31:0]                   csr_wdata
);

   // the unit stalls requests after accepting one, so none are taken back to back
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted back to back");

   // a new response must come after busy box decode, with req_stall high before it
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall) && $past(req_stall, 2) && $past(req_stall, 3))
      else $error("response without box decode");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_payload))
      else $error("response payload changed while stalled");

endmodule

bind anchor_box_decode_unit abd_checker u_abd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload),
   .csr_write   (csr_write),
   .csr_index   (csr_index),
   .csr_wdata   (csr_wdata)
);

`default_nettype wire
